>>> rtl/scfs_pkg.sv
// Shared package of the clause count and flip score unit.
// Holds sizes, command and change codes, and the structs between modules.
// Depends on nothing.
package scfs_pkg;

  localparam int MAX_CLAUSES     = 4096;
  localparam int MAX_VARS        = 1024;
  localparam int MAX_CLAUSE_LEN  = 31;
  localparam int MAX_OCCURRENCES = 256;

  localparam int CLAUSE_IDX_W = 12;
  localparam int CLAUSE_AW    = $clog2(MAX_CLAUSES);
  localparam int COUNT_W      = 5;
  localparam int VAR_W        = 10;
  localparam int UNSAT_W      = 13;
  localparam int SCORE_W      = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CLAUSE_LEN);
  localparam logic [UNSAT_W-1:0] UNSAT_MAX = UNSAT_W'(MAX_CLAUSES);
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = SCORE_W'(MAX_OCCURRENCES);
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = -SCORE_MAX;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FLIP  = 2'd1,
    CMD_SCORE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CHG_NONE  = 2'd0,
    CHG_SAT   = 2'd1,
    CHG_UNSAT = 2'd2
  } chg_t;

  // One request as held in the update stage.
  typedef struct packed {
    logic [1:0]              cmd;
    logic [CLAUSE_IDX_W-1:0] clause_index;
    logic                    negated;
    logic                    var_value;
    logic [COUNT_W-1:0]      count_value;
    logic [VAR_W-1:0]        var_index;
    logic                    last;
  } item_t;

  // What the update logic decides for one request.
  typedef struct packed {
    logic                       we;
    logic [COUNT_W-1:0]         wdata;
    logic [UNSAT_W-1:0]         unsat_next;
    logic signed [SCORE_W-1:0]  score_next;
    logic                       has_result;
    logic [1:0]                 clause_change;
    logic signed [SCORE_W-1:0]  score;
    logic [VAR_W-1:0]           score_var;
    logic                       score_valid;
  } upd_t;

endpackage

>>> rtl/scfs_if.sv
// Request and response channel interfaces of the clause count unit.
// Depends on scfs_pkg for field widths.
interface scfs_req_if;
  import scfs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic [CLAUSE_IDX_W-1:0] clause_index;
  logic                    negated;
  logic                    var_value;
  logic [COUNT_W-1:0]      count_value;
  logic [VAR_W-1:0]        var_index;
  logic                    last;

  modport source (output valid, cmd, clause_index, negated, var_value, count_value,
                  var_index, last, input ready);
  modport sink   (input valid, cmd, clause_index, negated, var_value, count_value,
                  var_index, last, output ready);
endinterface

interface scfs_rsp_if;
  import scfs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [UNSAT_W-1:0]        unsat_count;
  logic [1:0]                clause_change;
  logic signed [SCORE_W-1:0] score;
  logic [VAR_W-1:0]          score_var;
  logic                      score_valid;

  modport source (output valid, unsat_count, clause_change, score, score_var, score_valid,
                  input ready);
  modport sink   (input valid, unsat_count, clause_change, score, score_var, score_valid,
                  output ready);
endinterface

>>> rtl/scfs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents.
// Depends on nothing.
module scfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/scfs_update.sv
// Update logic: from one request, its clause count and the two totals,
// works out the write-back, the new totals and the response.
// Depends on scfs_pkg.
module scfs_update (
  input  scfs_pkg::item_t                     item,
  input  logic [scfs_pkg::COUNT_W-1:0]        count,
  input  logic [scfs_pkg::UNSAT_W-1:0]        unsat,
  input  logic signed [scfs_pkg::SCORE_W-1:0] score,
  output scfs_pkg::upd_t                      upd
);
  import scfs_pkg::*;

  logic               in_range;
  logic               lit_true;
  logic [COUNT_W-1:0] load_count;
  logic [COUNT_W-1:0] new_count;
  logic signed [SCORE_W-1:0] score_acc;

  assign in_range   = {1'b0, item.clause_index} < (CLAUSE_IDX_W+1)'(MAX_CLAUSES);
  assign lit_true   = item.var_value != item.negated;
  assign load_count = (item.count_value > COUNT_MAX) ? COUNT_MAX : item.count_value;

  always_comb begin
    if (lit_true) begin
      new_count = (count < COUNT_MAX) ? count + COUNT_W'(1) : count;
    end else begin
      new_count = (count != '0) ? count - COUNT_W'(1) : count;
    end
  end

  always_comb begin
    score_acc = score;
    if (in_range) begin
      if (count == '0 && !lit_true) begin
        if (score < SCORE_MAX) score_acc = score + SCORE_W'(1);
      end else if (count == COUNT_W'(1) && lit_true) begin
        if (score > SCORE_MIN) score_acc = score - SCORE_W'(1);
      end
    end
  end

  always_comb begin
    upd               = '0;
    upd.wdata         = load_count;
    upd.unsat_next    = unsat;
    upd.score_next    = score;
    upd.clause_change = CHG_NONE;
    unique case (cmd_t'(item.cmd))
      CMD_LOAD: begin
        upd.we    = in_range;
        upd.wdata = load_count;
        if (in_range && load_count == '0 && unsat < UNSAT_MAX) begin
          upd.unsat_next = unsat + UNSAT_W'(1);
        end
      end
      CMD_FLIP: begin
        upd.we         = in_range;
        upd.wdata      = new_count;
        upd.has_result = 1'b1;
        if (in_range && count == '0 && new_count != '0) begin
          upd.clause_change = CHG_SAT;
          if (unsat != '0) upd.unsat_next = unsat - UNSAT_W'(1);
        end else if (in_range && count != '0 && new_count == '0) begin
          upd.clause_change = CHG_UNSAT;
          if (unsat < UNSAT_MAX) upd.unsat_next = unsat + UNSAT_W'(1);
        end
      end
      CMD_SCORE: begin
        upd.score_next = score_acc;
        if (item.last) begin
          upd.has_result  = 1'b1;
          upd.score       = score_acc;
          upd.score_var   = item.var_index;
          upd.score_valid = 1'b1;
          upd.score_next  = '0;
        end
      end
      CMD_CLEAR: begin
        upd.unsat_next = '0;
        upd.score_next = '0;
      end
      default: begin
        upd.we = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/sat_clause_count_and_flip_score_unit.sv
// Top level of the clause count and flip score unit for local-search SAT.
// Depends on scfs_pkg, scfs_if, scfs_ram and scfs_update.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, clause_index, negated, var_value,
//                                count_value, var_index, last
//   rsp      out  valid/ready    unsat_count, clause_change, score,
//                                score_var, score_valid
//
// A request's clause count is read from the count RAM at the accepting edge;
// in the update stage it is updated and written back, and a flip or a last
// score request is registered and offered as the response. The read of the
// next request overlaps the update of the current one, so one request per
// cycle is sustained while the response side keeps up.
// Reset (rst, synchronous) clears the stage and output valid flags and both
// totals; the count RAM is not cleared and must be loaded before use.
// A response waiting in the output register stalls the update stage only
// when that stage has another response to give.
module sat_clause_count_and_flip_score_unit (
  input logic         clk,
  input logic         rst,
  scfs_req_if.sink    req,
  scfs_rsp_if.source  rsp
);
  import scfs_pkg::*;

  // Update stage: one request whose clause count is on the RAM output.
  logic  s1_valid;
  item_t s1_item;
  logic  s1_fire;
  logic  req_fire;

  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] count_cur;

  // The RAM returns old data when the request in the update stage writes
  // the same clause at the edge the next request is read, so that write is
  // kept here and forwarded.
  logic                 fwd_valid;
  logic [CLAUSE_AW-1:0] fwd_addr;
  logic [COUNT_W-1:0]   fwd_data;

  logic [UNSAT_W-1:0]        unsat_total;
  logic signed [SCORE_W-1:0] running_score;
  upd_t                      upd;

  logic                      out_valid;
  logic [UNSAT_W-1:0]        out_unsat;
  logic [1:0]                out_change;
  logic signed [SCORE_W-1:0] out_score;
  logic [VAR_W-1:0]          out_var;
  logic                      out_score_valid;

  assign s1_fire   = s1_valid && (!upd.has_result || !out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign req_fire  = req.valid && req.ready;

  scfs_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_CLAUSES)
  ) u_count_ram (
    .clk   (clk),
    .we    (s1_fire && upd.we),
    .waddr (s1_item.clause_index[CLAUSE_AW-1:0]),
    .wdata (upd.wdata),
    .re    (req_fire),
    .raddr (req.clause_index[CLAUSE_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign count_cur = (fwd_valid && fwd_addr == s1_item.clause_index[CLAUSE_AW-1:0])
                   ? fwd_data : ram_rdata;

  scfs_update u_update (
    .item  (s1_item),
    .count (count_cur),
    .unsat (unsat_total),
    .score (running_score),
    .upd   (upd)
  );

  // Stage register and forwarding register move together on acceptance,
  // so both hold while the stage is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid  <= 1'b1;
        fwd_valid <= s1_fire && upd.we;
      end else if (s1_fire) begin
        s1_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_item.cmd          <= req.cmd;
      s1_item.clause_index <= req.clause_index;
      s1_item.negated      <= req.negated;
      s1_item.var_value    <= req.var_value;
      s1_item.count_value  <= req.count_value;
      s1_item.var_index    <= req.var_index;
      s1_item.last         <= req.last;
      fwd_addr             <= s1_item.clause_index[CLAUSE_AW-1:0];
      fwd_data             <= upd.wdata;
    end
  end

  // Totals advance when the update stage completes a request.
  always_ff @(posedge clk) begin
    if (rst) begin
      unsat_total   <= '0;
      running_score <= '0;
    end else if (s1_fire) begin
      unsat_total   <= upd.unsat_next;
      running_score <= upd.score_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && upd.has_result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && upd.has_result) begin
      out_unsat       <= upd.unsat_next;
      out_change      <= upd.clause_change;
      out_score       <= upd.score;
      out_var         <= upd.score_var;
      out_score_valid <= upd.score_valid;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.unsat_count   = out_unsat;
  assign rsp.clause_change = out_change;
  assign rsp.score         = out_score;
  assign rsp.score_var     = out_var;
  assign rsp.score_valid   = out_score_valid;

endmodule
